### rtl/lidar_point_camera_box_gate_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lidar point camera box gate
// Concurrent checks on clk, compiled out for synthesis; LPCBG_ASSERT is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_CAMERA_BOX_GATE_UNIT_ASSERT_SVH
`define LIDAR_POINT_CAMERA_BOX_GATE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// check held outside reset
`define LPCBG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check held at every edge, reset included
`define LPCBG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPCBG_ASSERT(lbl, prop, msg)
`define LPCBG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/lpcbg_pkg.sv
// ----------------------------------------------------------------------------
// lpcbg_pkg
// Widths, constants and types shared by the box gate and its divider cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lpcbg_pkg;

  localparam int COORD_W   = 18;
  localparam int FRAC      = 4;            // pixel fraction bits
  localparam int DEN_SHIFT = 8 - FRAC;     // intrinsics carry 8 fraction bits
  localparam int AW        = COORD_W + 1;  // depth and offset sums
  localparam int PIX_W     = 20;
  localparam int NUM_W     = 39;           // projection numerator, signed
  localparam int REM_W     = NUM_W - 1;    // numerator magnitude
  localparam int DEN_W     = COORD_W + DEN_SHIFT; // |w| << DEN_SHIFT
  localparam int QUO_W     = PIX_W + 1;    // one extra bit flags overflow
  localparam int CMP_W     = DEN_W + QUO_W;
  localparam int CROP_W    = 33;

  // intrinsics, 1/256 pixel
  localparam logic signed [19:0] FX_Q8 = 20'sd146949;
  localparam logic signed [19:0] CX_Q8 = 20'sd81459;
  localparam logic signed [19:0] FY_Q8 = 20'sd147263;
  localparam logic signed [19:0] CY_Q8 = 20'sd63121;
  // crop slope 1.5526 as a ratio
  localparam logic signed [15:0] CROP_NUM = 16'sd15526;
  localparam logic signed [15:0] CROP_DEN = 16'sd10000;
  localparam logic signed [COORD_W-1:0] NEAR_MM = COORD_W'(10);

  // register indexes
  typedef enum logic [2:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_OFFSET_Z = 3'd2,
    REG_BOX_LEFT = 3'd3,
    REG_BOX_RIGHT = 3'd4,
    REG_BOX_TOP  = 3'd5,
    REG_BOX_BOTTOM = 3'd6
  } reg_idx_t;

  // per-item data that rides beside the divider cells
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [AW-1:0]      w;
    logic                      crop;
    logic                      neg_u;
    logic                      neg_v;
  } side_t;

endpackage
`default_nettype wire

### rtl/lpcbg_div_cell.sv
// ----------------------------------------------------------------------------
// lpcbg_div_cell
// One restoring-division step: tries den << K against the remainder and
// sets quotient bit K; registers the result for the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lpcbg_div_cell #(
  parameter int K = 0
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [lpcbg_pkg::REM_W-1:0] rem_in,
  input  wire logic [lpcbg_pkg::DEN_W-1:0] den_in,
  input  wire logic [lpcbg_pkg::QUO_W-1:0] quo_in,
  output logic      [lpcbg_pkg::REM_W-1:0] rem,
  output logic      [lpcbg_pkg::DEN_W-1:0] den,
  output logic      [lpcbg_pkg::QUO_W-1:0] quo
);
  import lpcbg_pkg::*;

  logic [CMP_W-1:0] shifted;
  logic             fits;
  logic [REM_W-1:0] rem_next;
  logic [QUO_W-1:0] quo_next;

  // compare and subtract
  always_comb begin
    shifted  = CMP_W'(den_in) << K;
    fits     = CMP_W'(rem_in) >= shifted;
    rem_next = fits ? REM_W'(CMP_W'(rem_in) - shifted) : rem_in;
    quo_next = quo_in;
    quo_next[K] = fits;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= rem_next;
      den <= den_in;
      quo <= quo_next;
    end
  end

endmodule
`default_nettype wire

### rtl/lidar_point_camera_box_gate_unit.sv
// ----------------------------------------------------------------------------
// lidar_point_camera_box_gate_unit
// Flips, crops and projects one lidar point per item onto the camera image
// and flags whether it lands strictly inside the configured box.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  s_*     | in  | tdata: point_x, point_y, point_z
//  m_*     | out | tdata: inside_box, pixel_u, pixel_v, depth_mm,
//          |     |        kept_x, kept_y, kept_z
//  cfg_*   | in  | write enable, register index, 16-bit data
//
// One item per cycle sustained. The pipeline runs through the offset,
// multiply, sum and magnitude stages, then a row of 21 divider cells (one
// quotient bit each, u and v side by side), then the output register.
// When the output item is not taken, the whole pipeline holds.
// Reset (rst, synchronous) clears the configuration registers and all valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lidar_point_camera_box_gate_unit_assert.svh"
module lidar_point_camera_box_gate_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [17:0] point_x, [35:18] point_y, [53:36] point_z, [55:54] zero
  input  wire logic [55:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [0] inside_box, [20:1] pixel_u, [40:21] pixel_v, [59:41] depth_mm,
  // [77:60] kept_x, [95:78] kept_y, [113:96] kept_z, [119:114] zero
  output logic      [119:0] m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [15:0]  cfg_data
);
  import lpcbg_pkg::*;

  localparam int NSTG = 4 + QUO_W;

  // configuration registers
  logic signed [15:0] offset_x, offset_y, offset_z;
  logic signed [11:0] box_left, box_right, box_top, box_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0; offset_y <= '0; offset_z <= '0;
      box_left <= '0; box_right <= '0; box_top <= '0; box_bottom <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_OFFSET_X:   offset_x   <= cfg_data;
        REG_OFFSET_Y:   offset_y   <= cfg_data;
        REG_OFFSET_Z:   offset_z   <= cfg_data;
        REG_BOX_LEFT:   box_left   <= cfg_data[11:0];
        REG_BOX_RIGHT:  box_right  <= cfg_data[11:0];
        REG_BOX_TOP:    box_top    <= cfg_data[11:0];
        REG_BOX_BOTTOM: box_bottom <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and valid bits
  logic            adv;
  logic [NSTG-1:0] vld;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld      <= {vld[NSTG-2:0], s_tvalid};
      m_tvalid <= vld[NSTG-1];
    end
  end

  // stage 1: flip z, add offsets, near test
  logic signed [COORD_W-1:0] in_x, in_y, in_z, flip_z;
  logic signed [COORD_W-1:0] x1, y1, z1;
  logic signed [AW-1:0]      w1, a1, b1;
  logic                      near1;

  always_comb begin
    in_x   = s_tdata[17:0];
    in_y   = s_tdata[35:18];
    in_z   = s_tdata[53:36];
    flip_z = (in_z == {1'b1, {(COORD_W-1){1'b0}}}) ? {1'b0, {(COORD_W-1){1'b1}}}
                                                    : COORD_W'(-in_z);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1    <= in_x;
      y1    <= in_y;
      z1    <= flip_z;
      w1    <= AW'(in_x) + AW'(offset_z);
      a1    <= AW'(in_y) + AW'(offset_x);
      b1    <= AW'(flip_z) + AW'(offset_y);
      near1 <= (in_x > NEAR_MM) && (in_y > NEAR_MM);
    end
  end

  // stage 2: products
  logic signed [COORD_W-1:0] x2, y2, z2;
  logic signed [AW-1:0]      w2;
  logic                      near2;
  logic signed [NUM_W-1:0]   fu2, cu2, fv2, cv2;
  logic signed [CROP_W-1:0]  crx2, cry2;

  always_ff @(posedge clk) begin
    if (adv) begin
      x2    <= x1; y2 <= y1; z2 <= z1; w2 <= w1; near2 <= near1;
      fu2   <= NUM_W'(FX_Q8) * NUM_W'(a1);
      cu2   <= NUM_W'(CX_Q8) * NUM_W'(w1);
      fv2   <= NUM_W'(FY_Q8) * NUM_W'(b1);
      cv2   <= NUM_W'(CY_Q8) * NUM_W'(w1);
      crx2  <= CROP_W'(x1) * CROP_W'(CROP_DEN);
      cry2  <= CROP_W'(y1) * CROP_W'(CROP_NUM);
    end
  end

  // stage 3: numerators and crop compare
  logic signed [COORD_W-1:0] x3, y3, z3;
  logic signed [AW-1:0]      w3;
  logic                      crop3;
  logic signed [NUM_W-1:0]   nu3, nv3;

  always_ff @(posedge clk) begin
    if (adv) begin
      x3    <= x2; y3 <= y2; z3 <= z2; w3 <= w2;
      crop3 <= near2 && (crx2 > cry2);
      nu3   <= fu2 + cu2;
      nv3   <= fv2 + cv2;
    end
  end

  // stage 4: magnitudes and quotient signs
  logic [AW-1:0]    w_mag;
  logic [REM_W-1:0] rem_u [QUO_W+1];
  logic [REM_W-1:0] rem_v [QUO_W+1];
  logic [DEN_W-1:0] den_u [QUO_W+1];
  logic [DEN_W-1:0] den_v [QUO_W+1];
  logic [QUO_W-1:0] quo_u [QUO_W+1];
  logic [QUO_W-1:0] quo_v [QUO_W+1];
  side_t            sb    [QUO_W+1];

  assign w_mag = w3[AW-1] ? AW'(-w3) : w3;

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_u[0] <= REM_W'(nu3[NUM_W-1] ? -nu3 : nu3);
      rem_v[0] <= REM_W'(nv3[NUM_W-1] ? -nv3 : nv3);
      den_u[0] <= {w_mag[COORD_W-1:0], {DEN_SHIFT{1'b0}}};
      den_v[0] <= {w_mag[COORD_W-1:0], {DEN_SHIFT{1'b0}}};
      quo_u[0] <= '0;
      quo_v[0] <= '0;
      sb[0]    <= '{x: x3, y: y3, z: z3, w: w3, crop: crop3,
                    neg_u: nu3[NUM_W-1] ^ w3[AW-1],
                    neg_v: nv3[NUM_W-1] ^ w3[AW-1]};
    end
  end

  // divider row, most significant quotient bit first
  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    lpcbg_div_cell #(.K(QUO_W - 1 - i)) u_cell (
      .clk(clk), .en(adv),
      .rem_in(rem_u[i]), .den_in(den_u[i]), .quo_in(quo_u[i]),
      .rem(rem_u[i+1]), .den(den_u[i+1]), .quo(quo_u[i+1])
    );
    lpcbg_div_cell #(.K(QUO_W - 1 - i)) v_cell (
      .clk(clk), .en(adv),
      .rem_in(rem_v[i]), .den_in(den_v[i]), .quo_in(quo_v[i]),
      .rem(rem_v[i+1]), .den(den_v[i+1]), .quo(quo_v[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) sb[i+1] <= sb[i];
    end
  end

  // signed, saturated quotient
  function automatic logic [PIX_W-1:0] sign_sat(input logic [QUO_W-1:0] q,
                                                 input logic neg);
    logic [QUO_W-1:0] lim_pos;
    logic [QUO_W-1:0] lim_neg;
    logic [QUO_W-1:0] q_neg;
    lim_pos = QUO_W'({1'b0, {(PIX_W-1){1'b1}}});
    lim_neg = QUO_W'({1'b1, {(PIX_W-1){1'b0}}});
    q_neg   = QUO_W'(0) - q;
    if (neg) sign_sat = (q > lim_neg) ? lim_neg[PIX_W-1:0] : q_neg[PIX_W-1:0];
    else     sign_sat = (q > lim_pos) ? lim_pos[PIX_W-1:0] : q[PIX_W-1:0];
  endfunction

  // output stage: saturate, box test
  side_t                   sf;
  logic signed [PIX_W-1:0] u_f, v_f;
  logic signed [PIX_W-1:0] lim_l, lim_r, lim_t, lim_b;
  logic                    w_zero, w_pos, inside_f;

  always_comb begin
    sf       = sb[QUO_W];
    w_zero   = (sf.w == '0);
    w_pos    = !sf.w[AW-1] && !w_zero;
    u_f      = w_zero ? '0 : sign_sat(quo_u[QUO_W], sf.neg_u);
    v_f      = w_zero ? '0 : sign_sat(quo_v[QUO_W], sf.neg_v);
    lim_l    = PIX_W'(box_left)   <<< FRAC;
    lim_r    = PIX_W'(box_right)  <<< FRAC;
    lim_t    = PIX_W'(box_top)    <<< FRAC;
    lim_b    = PIX_W'(box_bottom) <<< FRAC;
    inside_f = sf.crop && w_pos && (u_f > lim_l) && (u_f < lim_r) &&
               (v_f > lim_t) && (v_f < lim_b);
  end

  logic                      inside_box;
  logic signed [PIX_W-1:0]   pixel_u, pixel_v;
  logic signed [AW-1:0]      depth_mm;
  logic signed [COORD_W-1:0] kept_x, kept_y, kept_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      inside_box <= inside_f;
      pixel_u    <= u_f;
      pixel_v    <= v_f;
      depth_mm   <= sf.w;
      kept_x     <= sf.x;
      kept_y     <= sf.y;
      kept_z     <= sf.z;
    end
  end

  assign m_tdata = {6'b0, kept_z, kept_y, kept_x, depth_mm, pixel_v, pixel_u,
                    inside_box};

  // checks
  `LPCBG_ASSERT(a_zero_depth, m_tvalid && depth_mm == '0 |-> pixel_u == '0 && pixel_v == '0, "nonzero pixel at zero depth")
  `LPCBG_ASSERT(a_inside_pos, m_tvalid && inside_box |-> !depth_mm[AW-1] && depth_mm != '0, "inside flag without positive depth")
  `LPCBG_ASSERT(a_flip_sat, m_tvalid |-> kept_z != {1'b1, {(COORD_W-1){1'b0}}}, "flipped z not saturated")
  `LPCBG_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled item lost")
  `LPCBG_ASSERT_ALWAYS(a_rst_clear, rst |=> !m_tvalid && vld == '0, "valid after reset")

endmodule
`default_nettype wire

### tb/sv/lidar_point_camera_box_gate_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_camera_box_gate_unit_checker
// Watches the point, result and register channels of the box gate, predicts
// every result from its own copy of the registers and compares field by field.
// ----------------------------------------------------------------------------
module lidar_point_camera_box_gate_unit_checker
  import lpcbg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [55:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [119:0] m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [15:0]  cfg_data,
  output int           fail_count,
  output int           pending_results
);

  // register copy
  longint off_x, off_y, off_z, left_px, right_px, top_px, bottom_px;
  logic [119:0] projected_q[$];

  function automatic longint clamp(longint a, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (a > hi) return hi;
    if (a < lo) return lo;
    return a;
  endfunction

  // expected result item for one point
  function automatic logic [119:0] project_point(logic [55:0] d);
    longint x, y, z, w, u, v, wd;
    bit crop, in_box;
    x = longint'($signed(d[17:0]));
    y = longint'($signed(d[35:18]));
    z = clamp(-longint'($signed(d[53:36])), 18);
    w = x + off_z;
    u = 0;
    v = 0;
    if (w != 0) begin
      u = clamp((longint'(146949) * (y + off_x) + longint'(81459) * w) / (w * 16), 20);
      v = clamp((longint'(147263) * (z + off_y) + longint'(63121) * w) / (w * 16), 20);
    end
    crop = x > 10 && y > 10 && x * 10000 > y * 15526;
    in_box = crop && w > 0 && u > left_px * 16 && u < right_px * 16 &&
             v > top_px * 16 && v < bottom_px * 16;
    wd = clamp(w, 19);
    return {6'b0, z[17:0], y[17:0], x[17:0], wd[18:0], v[19:0], u[19:0], in_box};
  endfunction

  task automatic report(input string field, input logic [19:0] got, input logic [19:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
  end

  assign pending_results = projected_q.size();

  // snoop channels at the rising edge
  always @(posedge clk) begin
    logic [119:0] want;
    if (rst) begin
      off_x = 0; off_y = 0; off_z = 0;
      left_px = 0; right_px = 0; top_px = 0; bottom_px = 0;
      projected_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_OFFSET_X:   off_x = longint'($signed(cfg_data));
          REG_OFFSET_Y:   off_y = longint'($signed(cfg_data));
          REG_OFFSET_Z:   off_z = longint'($signed(cfg_data));
          REG_BOX_LEFT:   left_px = longint'($signed(cfg_data[11:0]));
          REG_BOX_RIGHT:  right_px = longint'($signed(cfg_data[11:0]));
          REG_BOX_TOP:    top_px = longint'($signed(cfg_data[11:0]));
          REG_BOX_BOTTOM: bottom_px = longint'($signed(cfg_data[11:0]));
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) projected_q = {projected_q, project_point(s_tdata)};
      if (m_tvalid && m_tready) begin
        if (projected_q.size() == 0) begin
          $display("result item with no point outstanding: %h", m_tdata);
          fail_count++;
        end else begin
          want = projected_q.pop_front();
          if (m_tdata[0] !== want[0]) report("inside_box", m_tdata[0], want[0]);
          if (m_tdata[20:1] !== want[20:1]) report("pixel_u", m_tdata[20:1], want[20:1]);
          if (m_tdata[40:21] !== want[40:21]) report("pixel_v", m_tdata[40:21], want[40:21]);
          if (m_tdata[59:41] !== want[59:41]) report("depth_mm", m_tdata[59:41], want[59:41]);
          if (m_tdata[77:60] !== want[77:60]) report("kept_x", m_tdata[77:60], want[77:60]);
          if (m_tdata[95:78] !== want[95:78]) report("kept_y", m_tdata[95:78], want[95:78]);
          if (m_tdata[113:96] !== want[113:96]) report("kept_z", m_tdata[113:96], want[113:96]);
          if (m_tdata[119:114] !== want[119:114]) report("pad", m_tdata[119:114], 0);
        end
      end
    end
  end

endmodule

### tb/sv/tb_lidar_point_camera_box_gate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_point_camera_box_gate_unit
// Drives directed and random lidar points through the box gate under several
// register settings with random idling on both sides; the checker judges.
// ----------------------------------------------------------------------------
module tb_lidar_point_camera_box_gate_unit;
  import lpcbg_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [55:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [119:0] m_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [15:0]  cfg_data;
  int           fail_count;
  int           pending_results;
  bit           idle_on;
  int           quiet_cycles;

  lidar_point_camera_box_gate_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  lidar_point_camera_box_gate_unit_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side stalls
  always @(negedge clk) m_tready <= idle_on ? ($urandom_range(99) >= 16) : 1'b1;

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("lidar_point_camera_box_gate_unit regression: fail");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic push_point(input logic [17:0] x, input logic [17:0] y, input logic [17:0] z);
    while (idle_on && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b0, z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // block must be drained before this
  task automatic write_regs(input logic [15:0] ox, input logic [15:0] oy, input logic [15:0] oz,
                            input logic [11:0] bl, input logic [11:0] br,
                            input logic [11:0] bt, input logic [11:0] bb);
    logic [15:0] vals[8];
    vals = '{ox, oy, oz, {4'b0, bl}, {4'b0, br}, {4'b0, bt}, {4'b0, bb}, 16'hffff};
    s_tvalid <= 1'b0;
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= i[2:0];
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    wait (pending_results == 0);
    repeat (40) @(negedge clk);
  endtask

  // mostly plausible forward points, some raw noise
  task automatic random_points(input int count);
    int x, y, z;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        push_point($urandom, $urandom, $urandom);
      end else begin
        x = $urandom_range(40000, 200);
        y = $urandom_range(x * 10 / 15, 5) - ($urandom_range(3) == 0 ? 2000 : 0);
        z = $urandom_range(8000) - 4000;
        push_point(x[17:0], y[17:0], z[17:0]);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, zero depth, flip overflow, crop edges
    push_point(18'h1ffff, 18'h1ffff, 18'h1ffff);
    push_point(18'h20000, 18'h20000, 18'h20000);
    push_point(18'd0, 18'd0, 18'd0);
    push_point(18'd11, 18'd11, 18'd5);
    push_point(18'd10, 18'd11, 18'd5);
    push_point(18'd15526, 18'd10000, 18'd100);
    push_point(18'd15527, 18'd10000, 18'd100);
    push_point(18'd5000, 18'd10, 18'h20000);
    push_point(-18'sd500, 18'd20, 18'd100);
    push_point(18'h1ffff, 18'h20000, 18'h3ffff);
    drain();
    write_regs(16'd100, -16'sd50, -16'sd2000, 12'd100, 12'd540, 12'd50, 12'd430);
    push_point(18'd2000, 18'd300, 18'd100);
    push_point(18'd4000, 18'd100, -18'sd50);
    push_point(18'd2000, 18'd50, 18'd0);
    push_point(18'd3000, 18'd500, 18'd200);
    push_point(18'd1999, 18'd100, 18'd0);
    drain();
    write_regs(16'h7fff, 16'h7fff, 16'h7fff, 12'h7ff, 12'h7ff, 12'h7ff, 12'h7ff);
    push_point(18'h1ffff, 18'd20, 18'h20000);
    push_point(18'd20000, 18'd100, 18'd0);
    drain();
    write_regs(16'h8000, 16'h8000, 16'h8000, 12'h800, 12'h7ff, 12'h800, 12'h7ff);
    push_point(18'h1ffff, 18'd20, 18'h1ffff);
    push_point(18'd32768, 18'd100, 18'd0);
    push_point(18'd20000, 18'd100, 18'd7);
    drain();

    // random phases under varied settings
    for (int ph = 0; ph < 6; ph++) begin
      idle_on = (ph != 2);
      if (ph == 5)
        write_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        write_regs($urandom_range(400) - 200, $urandom_range(400) - 200,
                   $urandom_range(600) - 300, $urandom_range(250), $urandom_range(640, 300),
                   $urandom_range(200), $urandom_range(480, 250));
      random_points(100);
      drain();
    end

    if (fail_count == 0) begin
      $display("lidar_point_camera_box_gate_unit regression: pass");
    end else begin
      $display("lidar_point_camera_box_gate_unit regression: fail");
    end
    $finish;
  end

endmodule

### lidar_point_camera_box_gate_unit.f
+incdir+rtl
rtl/lpcbg_pkg.sv
rtl/lpcbg_div_cell.sv
rtl/lidar_point_camera_box_gate_unit.sv
tb/sv/lidar_point_camera_box_gate_unit_checker.sv
tb/sv/tb_lidar_point_camera_box_gate_unit.sv
